### rtl/tlct_pkg.sv
// Shared constants, types and a helper function of the two-link computed-torque core.
`timescale 1ns / 1ps
package tlct_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int TRIG_SHIFT = 30;
   localparam int STAGES     = 13;
   localparam int LANES      = 4;

   localparam logic [30:0] TRIG_ONE = 31'h4000_0000;

   // Odd Taylor coefficients of the quarter-wave sine, Q30, lowest order first.
   localparam logic [30:0] SIN_COEF [6] = '{
      31'd1686629713, 31'd693598668, 31'd85569306,
      31'd5026995,    31'd172272,    31'd3864
   };

   typedef enum logic [2:0] {
      CSR_INERTIA_BASE  = 3'd0,
      CSR_INERTIA_CROSS = 3'd1,
      CSR_INERTIA_TIP   = 3'd2,
      CSR_GRAVITY_INNER = 3'd3,
      CSR_GRAVITY_OUTER = 3'd4
   } csr_index_type;

   // Clamps a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/two_link_computed_torque_core.sv
// Top level of the two-link computed-torque feedforward pipeline.
`timescale 1ns / 1ps
// Computed-torque feedforward for a two-link planar arm. Each request transfer carries one
// desired state (two angles in binary angle units, two rates, two accelerations in Q16.16);
// each response transfer carries the inertia, Coriolis and gravity torques of both joints,
// saturated to 32 bits. The core is a 13-stage pipeline that takes one request per cycle
// unless rsp_tready holds the output back; the depth is set by the seven-multiply sine
// polynomial followed by the coefficient, torque and Coriolis multiply stages. Four sine
// lanes work in parallel. Stages that hold no item do not stall those behind them. The five
// coefficient registers are written over the csr port, which is always ready; writes to an
// index past the last register are ignored.
module two_link_computed_torque_core (
   input  logic         clock,
   input  logic         reset,
   // angle_one, angle_two, rate_one, rate_two, accel_one, accel_two
   input  logic [159:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // inertia_torque_one, inertia_torque_two, coriolis_torque_one, coriolis_torque_two,
   // gravity_torque_one, gravity_torque_two
   output logic [191:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int NS = tlct_pkg::STAGES;
   localparam int NL = tlct_pkg::LANES;

   logic signed [31:0] base_ff, cross_ff, tip_ff, inner_ff, outer_ff;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   // Stage 0 input capture and carried operands.
   logic [15:0]        ang1_ff, ang2_ff;
   logic signed [31:0] r1_ff [11];
   logic signed [31:0] r2_ff [11];
   logic signed [31:0] a1_ff [10];
   logic signed [31:0] a2_ff [10];

   // Sine lanes: 0 cos(a2), 1 sin(a2), 2 cos(a1), 3 cos(a1+a2).
   logic [30:0] f_ff   [1:7][NL];
   logic        neg_ff [1:7][NL];
   logic [30:0] z_ff   [2:6][NL];
   logic [30:0] acc_ff [3:7][NL];
   logic signed [31:0] trig_ff [NL];

   logic signed [32:0] cc_ff, h_ff;
   logic signed [31:0] grav1_ff [9:NS-1];
   logic signed [31:0] grav2_ff [9:NS-1];
   logic signed [48:0] ba_ff, cca1_ff, ta2_ff, cca2_ff, ta1_ff;
   logic signed [31:0] hr2_ff, hr1_ff;
   logic signed [31:0] in0_ff, in1_ff;
   logic signed [47:0] ca_ff, cb_ff, cx_ff;
   logic signed [31:0] out0_ff, out1_ff, out2_ff, out3_ff;

   // A stage may load when it is empty or when its contents move on.
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = {grav2_ff[NS-1], grav1_ff[NS-1], out3_ff, out2_ff, out1_ff, out0_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         base_ff  <= '0;
         cross_ff <= '0;
         tip_ff   <= '0;
         inner_ff <= '0;
         outer_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (csr_valid) begin
            case (csr_addr)
               tlct_pkg::CSR_INERTIA_BASE:  base_ff  <= csr_wdata;
               tlct_pkg::CSR_INERTIA_CROSS: cross_ff <= csr_wdata;
               tlct_pkg::CSR_INERTIA_TIP:   tip_ff   <= csr_wdata;
               tlct_pkg::CSR_GRAVITY_INNER: inner_ff <= csr_wdata;
               tlct_pkg::CSR_GRAVITY_OUTER: outer_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Stage 1: phases folded into a quarter wave.
   logic [30:0] f_in   [NL];
   logic        neg_in [NL];
   always_comb begin
      logic [31:0] p1, p2;
      logic [31:0] ph [NL];
      logic [30:0] fr;
      p1 = {{(32 - 16){ang1_ff[15]}}, ang1_ff} << (32 - tlct_pkg::ANGLE_BITS);
      p2 = {{(32 - 16){ang2_ff[15]}}, ang2_ff} << (32 - tlct_pkg::ANGLE_BITS);
      ph[0] = p2 + 32'h4000_0000;
      ph[1] = p2;
      ph[2] = p1 + 32'h4000_0000;
      ph[3] = p1 + p2 + 32'h4000_0000;
      for (int l = 0; l < NL; l++) begin
         fr = {1'b0, ph[l][29:0]};
         f_in[l]   = ph[l][30] ? (tlct_pkg::TRIG_ONE - fr) : fr;
         neg_in[l] = ph[l][31];
      end
   end

   // Stages 2 to 8: square, Horner steps and the final multiply by the fraction.
   logic [30:0]        z_in    [NL];
   logic [30:0]        acc_in  [3:7][NL];
   logic signed [31:0] trig_in [NL];
   always_comb begin
      logic [61:0] sq, pr;
      logic [30:0] s;
      for (int l = 0; l < NL; l++) begin
         sq = 62'(f_ff[1][l]) * 62'(f_ff[1][l]);
         z_in[l] = sq[60:30];
         pr = 62'(tlct_pkg::SIN_COEF[5]) * 62'(z_ff[2][l]);
         acc_in[3][l] = tlct_pkg::SIN_COEF[4] - pr[60:30];
         for (int k = 4; k <= 7; k++) begin
            pr = 62'(acc_ff[k-1][l]) * 62'(z_ff[k-1][l]);
            acc_in[k][l] = tlct_pkg::SIN_COEF[7-k] - pr[60:30];
         end
         pr = 62'(acc_ff[7][l]) * 62'(f_ff[7][l]);
         s = (pr[61:30] > 32'(tlct_pkg::TRIG_ONE)) ? tlct_pkg::TRIG_ONE : pr[60:30];
         trig_in[l] = neg_ff[7][l] ? -$signed({1'b0, s}) : $signed({1'b0, s});
      end
   end

   // Stage 9: trig products with the coefficients, gravity outputs.
   logic signed [32:0] cc_in, h_in;
   logic signed [31:0] g1_in, g2_in;
   always_comb begin
      logic signed [63:0] pc, ps, pi, po;
      logic signed [33:0] gs;
      pc = 64'(cross_ff) * 64'(trig_ff[0]);
      ps = 64'(cross_ff) * 64'(trig_ff[1]);
      pi = 64'(inner_ff) * 64'(trig_ff[2]);
      po = 64'(outer_ff) * 64'(trig_ff[3]);
      cc_in = pc[62:30];
      h_in  = ps[62:30];
      gs    = 34'(signed'(pi[62:30])) + 34'(signed'(po[62:30]));
      g1_in = tlct_pkg::sat32(64'(gs));
      g2_in = tlct_pkg::sat32(64'(signed'(po[62:30])));
   end

   // Stage 10: inertia products and the first Coriolis factor.
   logic signed [48:0] ba_in, cca1_in, ta2_in, cca2_in, ta1_in;
   logic signed [31:0] hr2_in, hr1_in;
   always_comb begin
      logic signed [64:0] p;
      p = 65'(base_ff) * 65'(a1_ff[9]);
      ba_in = 49'(p >>> tlct_pkg::FRAC_BITS);
      p = 65'(cc_ff) * 65'(a1_ff[9]);
      cca1_in = 49'(p >>> tlct_pkg::FRAC_BITS);
      p = 65'(tip_ff) * 65'(a2_ff[9]);
      ta2_in = 49'(p >>> tlct_pkg::FRAC_BITS);
      p = 65'(cc_ff) * 65'(a2_ff[9]);
      cca2_in = 49'(p >>> tlct_pkg::FRAC_BITS);
      p = 65'(tip_ff) * 65'(a1_ff[9]);
      ta1_in = 49'(p >>> tlct_pkg::FRAC_BITS);
      p = 65'(h_ff) * 65'(r2_ff[9]);
      hr2_in = tlct_pkg::sat32(64'(p >>> tlct_pkg::FRAC_BITS));
      p = 65'(h_ff) * 65'(r1_ff[9]);
      hr1_in = tlct_pkg::sat32(64'(p >>> tlct_pkg::FRAC_BITS));
   end

   // Stage 11: inertia sums and second Coriolis products.
   logic signed [31:0] in0_in, in1_in;
   logic signed [47:0] ca_in, cb_in, cx_in;
   always_comb begin
      logic signed [52:0] s0, s1;
      logic signed [63:0] p;
      s0 = 53'(ba_ff) + (53'(cca1_ff) <<< 1) + 53'(ta2_ff) + 53'(cca2_ff);
      s1 = 53'(ta1_ff) + 53'(cca1_ff) + 53'(ta2_ff);
      in0_in = tlct_pkg::sat32(64'(s0));
      in1_in = tlct_pkg::sat32(64'(s1));
      p = 64'(hr2_ff) * 64'(r1_ff[10]);
      ca_in = 48'(p >>> tlct_pkg::FRAC_BITS);
      p = 64'(hr2_ff) * 64'(r2_ff[10]);
      cb_in = 48'(p >>> tlct_pkg::FRAC_BITS);
      p = 64'(hr1_ff) * 64'(r1_ff[10]);
      cx_in = 48'(p >>> tlct_pkg::FRAC_BITS);
   end

   // Stage 12: Coriolis totals into the output register.
   logic signed [31:0] out2_in, out3_in;
   always_comb begin
      logic signed [50:0] t;
      t = (51'(ca_ff) <<< 1) + 51'(cb_ff);
      out2_in = tlct_pkg::sat32(64'(-t));
      out3_in = tlct_pkg::sat32(64'(cx_ff));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ang1_ff  <= req_tdata[15:0];
         ang2_ff  <= req_tdata[31:16];
         r1_ff[0] <= req_tdata[63:32];
         r2_ff[0] <= req_tdata[95:64];
         a1_ff[0] <= req_tdata[127:96];
         a2_ff[0] <= req_tdata[159:128];
      end
      for (int k = 1; k <= 10; k++) begin
         if (en[k]) begin
            r1_ff[k] <= r1_ff[k-1];
            r2_ff[k] <= r2_ff[k-1];
         end
      end
      for (int k = 1; k <= 9; k++) begin
         if (en[k]) begin
            a1_ff[k] <= a1_ff[k-1];
            a2_ff[k] <= a2_ff[k-1];
         end
      end
      for (int k = 10; k < NS; k++) begin
         if (en[k]) begin
            grav1_ff[k] <= grav1_ff[k-1];
            grav2_ff[k] <= grav2_ff[k-1];
         end
      end
      for (int k = 2; k <= 7; k++) begin
         if (en[k]) begin
            for (int l = 0; l < NL; l++) begin
               f_ff[k][l]   <= f_ff[k-1][l];
               neg_ff[k][l] <= neg_ff[k-1][l];
            end
         end
      end
      for (int k = 3; k <= 6; k++) begin
         if (en[k]) begin
            for (int l = 0; l < NL; l++) begin
               z_ff[k][l] <= z_ff[k-1][l];
            end
         end
      end
      for (int k = 3; k <= 7; k++) begin
         if (en[k]) begin
            for (int l = 0; l < NL; l++) begin
               acc_ff[k][l] <= acc_in[k][l];
            end
         end
      end
      if (en[1]) begin
         for (int l = 0; l < NL; l++) begin
            f_ff[1][l]   <= f_in[l];
            neg_ff[1][l] <= neg_in[l];
         end
      end
      if (en[2]) begin
         for (int l = 0; l < NL; l++) begin
            z_ff[2][l] <= z_in[l];
         end
      end
      if (en[8]) begin
         trig_ff <= trig_in;
      end
      if (en[9]) begin
         cc_ff       <= cc_in;
         h_ff        <= h_in;
         grav1_ff[9] <= g1_in;
         grav2_ff[9] <= g2_in;
      end
      if (en[10]) begin
         ba_ff   <= ba_in;
         cca1_ff <= cca1_in;
         ta2_ff  <= ta2_in;
         cca2_ff <= cca2_in;
         ta1_ff  <= ta1_in;
         hr2_ff  <= hr2_in;
         hr1_ff  <= hr1_in;
      end
      if (en[11]) begin
         in0_ff <= in0_in;
         in1_ff <= in1_in;
         ca_ff  <= ca_in;
         cb_ff  <= cb_in;
         cx_ff  <= cx_in;
      end
      if (en[12]) begin
         out0_ff <= in0_ff;
         out1_ff <= in1_ff;
         out2_ff <= out2_in;
         out3_ff <= out3_in;
      end
   end

endmodule
